@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the lattice walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GSAW_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GSAW_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`endif

@@ rtl/core/gsaw_pkg.sv @@
// Package of types and constants for the growing self-avoiding walk block.
package gsaw_pkg;

   localparam int unsigned DIM_DEFAULT = 512;
   localparam int unsigned POS_W       = 9;
   localparam int unsigned STEP_W      = 16;
   localparam int unsigned SUM_W       = 33;
   localparam int unsigned RND_W       = 16;

   localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 16'd1024;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RD_R,
      ST_RD_L,
      ST_RD_C,
      ST_PICK,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef struct packed {
      logic start;
      logic step;
      logic ignore;
      logic clear;
      logic rd_r;
      logic rd_l;
      logic rd_c;
      logic pick;
      logic write;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic live;
      logic clear_last;
      logic dead;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/gsaw_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module gsaw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/gsaw_ctrl.sv @@
// Controller state machine that sequences start and step items for the walker.
module gsaw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_stall,
   input  gsaw_pkg::status_type  status,
   output gsaw_pkg::cmd_type     cmd
);
   import gsaw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACT_START) begin
                  cmd.start = 1'b1;
                  state_in  = ST_CLEAR;
               end else if (status.live) begin
                  cmd.step = 1'b1;
                  state_in = ST_RD_R;
               end else begin
                  cmd.ignore = 1'b1;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_RD_R: begin
            cmd.rd_r = 1'b1;
            state_in = ST_RD_L;
         end
         ST_RD_L: begin
            cmd.rd_l = 1'b1;
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_c = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = status.dead ? ST_EMIT : ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/gsaw_dp.sv @@
// Datapath of the walker: position, counters, lattice memory and result register.
module gsaw_dp #(
   parameter int unsigned DIM = gsaw_pkg::DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gsaw_pkg::cmd_type                 cmd,
   output gsaw_pkg::status_type              status,
   input  logic [gsaw_pkg::RND_W-1:0]        req_random_word,
   input  logic                              csr_wr_en,
   input  logic [gsaw_pkg::STEP_W-1:0]       csr_wr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [gsaw_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [gsaw_pkg::POS_W-1:0]        rsp_pos_y,
   output logic                              rsp_alive,
   output logic                              rsp_done_res,
   output logic [gsaw_pkg::STEP_W-1:0]       rsp_step_total,
   output logic [gsaw_pkg::SUM_W-1:0]        rsp_sum_sq_dist
);
   import gsaw_pkg::*;

   localparam int unsigned AW  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int unsigned CW  = AW + 1;
   localparam int unsigned SQW = 2 * CW;
   localparam logic [AW-1:0]  CENTRE   = AW'(DIM / 2);
   localparam logic [AW-1:0]  LAST_ROW = AW'(DIM - 1);
   localparam logic [AW:0]    DIM_EXT  = CW'(DIM);
   localparam logic [DIM-1:0] ROW_ONE  = DIM'(1);

   // Walker state.
   logic [AW-1:0]     cur_x_ff, cur_x_in;
   logic [AW-1:0]     cur_y_ff, cur_y_in;
   logic              alive_ff, alive_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [STEP_W-1:0] max_steps_ff, max_steps_in;
   logic [AW-1:0]     row_cnt_ff, row_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   logic [AW-1:0]     rec_x_ff, rec_x_in;
   logic [AW-1:0]     rec_y_ff, rec_y_in;
   logic              done_ff, done_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic [SQW-1:0]    sq_x_ff, sq_x_in;
   logic [SQW-1:0]    sq_y_ff, sq_y_in;
   logic              free_r_ff, free_r_in;
   logic              free_l_ff, free_l_in;

   // Result register.
   logic [POS_W-1:0]  out_x_ff, out_x_in;
   logic [POS_W-1:0]  out_y_ff, out_y_in;
   logic              out_alive_ff, out_alive_in;
   logic              out_done_ff, out_done_in;
   logic [STEP_W-1:0] out_steps_ff, out_steps_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;

   // Lattice memory, one row of DIM bits per x coordinate.
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DIM-1:0]    ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DIM-1:0]    ram_rd_data;

   logic              r_ok, l_ok, u_ok, d_ok;
   logic              free_u, free_d;
   logic [3:0]        free_vec;
   logic [2:0]        nfree;
   logic [RND_W+2:0]  prod;
   logic [1:0]        k_pick;
   logic [1:0]        remain;
   logic              found;
   dir_type           sel_dir;
   logic [AW-1:0]     new_x, new_y;
   logic signed [CW-1:0]  dx, dy;
   logic signed [SQW-1:0] dx_sq, dy_sq;

   gsaw_ram #(
      .WIDTH (DIM),
      .DEPTH (DIM)
   ) u_lattice (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Neighbour bounds, the up and down bits of the current row and the squared offsets from the centre.
   always_comb begin
      r_ok   = ({1'b0, cur_x_ff} + CW'(1)) < DIM_EXT;
      u_ok   = ({1'b0, cur_y_ff} + CW'(1)) < DIM_EXT;
      l_ok   = (cur_x_ff != '0);
      d_ok   = (cur_y_ff != '0);
      free_u = u_ok ? ~ram_rd_data[cur_y_ff + AW'(1)] : 1'b0;
      free_d = d_ok ? ~ram_rd_data[cur_y_ff - AW'(1)] : 1'b0;
      dx     = $signed({1'b0, cur_x_ff}) - $signed({1'b0, CENTRE});
      dy     = $signed({1'b0, cur_y_ff}) - $signed({1'b0, CENTRE});
      dx_sq  = dx * dx;
      dy_sq  = dy * dy;
   end

   // Choose the k-th free neighbour in the order up, down, right, left.
   always_comb begin
      free_vec = {free_l_ff, free_r_ff, free_d, free_u};
      nfree    = 3'(free_vec[0]) + 3'(free_vec[1]) + 3'(free_vec[2]) + 3'(free_vec[3]);
      prod     = rnd_ff * nfree;
      k_pick   = prod[RND_W+1:RND_W];
      remain   = k_pick;
      found    = 1'b0;
      sel_dir  = DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (free_vec[i] && !found) begin
            if (remain == 2'd0) begin
               sel_dir = dir_type'(2'(i));
               found   = 1'b1;
            end else begin
               remain = remain - 2'd1;
            end
         end
      end
      new_x = cur_x_ff;
      new_y = cur_y_ff;
      case (sel_dir)
         DIR_UP:    new_y = cur_y_ff + AW'(1);
         DIR_DOWN:  new_y = cur_y_ff - AW'(1);
         DIR_RIGHT: new_x = cur_x_ff + AW'(1);
         DIR_LEFT:  new_x = cur_x_ff - AW'(1);
         default:   new_x = cur_x_ff;
      endcase
   end

   // Memory port control.
   always_comb begin
      ram_wr_en   = cmd.clear || cmd.write;
      ram_wr_addr = cmd.clear ? row_cnt_ff : cur_x_ff;
      if (cmd.clear) begin
         ram_wr_data = (row_cnt_ff == CENTRE) ? (ROW_ONE << CENTRE) : '0;
      end else begin
         // The row of the new site was read again in the previous cycle.
         ram_wr_data = ram_rd_data | (ROW_ONE << cur_y_ff);
      end
      ram_rd_en   = (cmd.rd_r && r_ok) || (cmd.rd_l && l_ok) || cmd.rd_c
                    || (cmd.pick && (nfree != 3'd0));
      ram_rd_addr = cur_x_ff;
      if (cmd.rd_r) begin
         ram_rd_addr = cur_x_ff + AW'(1);
      end else if (cmd.rd_l) begin
         ram_rd_addr = cur_x_ff - AW'(1);
      end else if (cmd.pick) begin
         ram_rd_addr = new_x;
      end
   end

   always_comb begin
      status.live       = alive_ff && (steps_ff < max_steps_ff);
      status.clear_last = (row_cnt_ff == LAST_ROW);
      status.dead       = (nfree == 3'd0);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      alive_in     = alive_ff;
      steps_in     = steps_ff;
      sum_in       = sum_ff;
      max_steps_in = csr_wr_en ? csr_wr_data : max_steps_ff;
      row_cnt_in   = row_cnt_ff;
      rec_x_in     = rec_x_ff;
      rec_y_in     = rec_y_ff;
      done_in      = done_ff;
      rnd_in       = rnd_ff;
      sq_x_in      = sq_x_ff;
      sq_y_in      = sq_y_ff;
      free_r_in    = free_r_ff;
      free_l_in    = free_l_ff;

      if (cmd.start) begin
         cur_x_in   = CENTRE;
         cur_y_in   = CENTRE;
         alive_in   = 1'b1;
         steps_in   = '0;
         sum_in     = '0;
         row_cnt_in = '0;
         rec_x_in   = CENTRE;
         rec_y_in   = CENTRE;
         done_in    = 1'b0;
      end
      if (cmd.ignore) begin
         rec_x_in = cur_x_ff;
         rec_y_in = cur_y_ff;
         done_in  = 1'b1;
      end
      if (cmd.step) begin
         rec_x_in = cur_x_ff;
         rec_y_in = cur_y_ff;
         done_in  = 1'b0;
         rnd_in   = req_random_word;
      end
      if (cmd.clear) begin
         row_cnt_in = row_cnt_ff + AW'(1);
      end
      if (cmd.rd_r) begin
         sq_x_in = $unsigned(dx_sq);
         sq_y_in = $unsigned(dy_sq);
      end
      if (cmd.rd_l) begin
         free_r_in = r_ok && !ram_rd_data[cur_y_ff];
         sum_in    = sum_ff + SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);
         steps_in  = steps_ff + STEP_W'(1);
      end
      if (cmd.rd_c) begin
         free_l_in = l_ok && !ram_rd_data[cur_y_ff];
      end
      if (cmd.pick) begin
         if (nfree == 3'd0) begin
            alive_in = 1'b0;
         end else begin
            cur_x_in = new_x;
            cur_y_in = new_y;
         end
      end
   end

   always_comb begin
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_alive_in = out_alive_ff;
      out_done_in  = out_done_ff;
      out_steps_in = out_steps_ff;
      out_sum_in   = out_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_x_in     = POS_W'(rec_x_ff);
         out_y_in     = POS_W'(rec_y_ff);
         out_alive_in = alive_ff;
         out_done_in  = done_ff;
         out_steps_in = steps_ff;
         out_sum_in   = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= CENTRE;
         cur_y_ff     <= CENTRE;
         alive_ff     <= 1'b0;
         steps_ff     <= '0;
         sum_ff       <= '0;
         max_steps_ff <= MAX_STEPS_RESET;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         alive_ff     <= alive_in;
         steps_ff     <= steps_in;
         sum_ff       <= sum_in;
         max_steps_ff <= max_steps_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_x_ff     <= rec_x_in;
      rec_y_ff     <= rec_y_in;
      done_ff      <= done_in;
      rnd_ff       <= rnd_in;
      sq_x_ff      <= sq_x_in;
      sq_y_ff      <= sq_y_in;
      free_r_ff    <= free_r_in;
      free_l_ff    <= free_l_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_alive_ff <= out_alive_in;
      out_done_ff  <= out_done_in;
      out_steps_ff <= out_steps_in;
      out_sum_ff   <= out_sum_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_alive       = out_alive_ff;
   assign rsp_done_res    = out_done_ff;
   assign rsp_step_total  = out_steps_ff;
   assign rsp_sum_sq_dist = out_sum_ff;

endmodule

@@ rtl/core/growing_self_avoiding_walk_top.sv @@
// A counted step is sequenced through the states RD_R, RD_L, RD_C, PICK, WRITE and EMIT
// (PICK goes straight to EMIT when the walker dies); the RAM's single read port takes three
// row reads and one re-read of the new row. An ignored step goes straight to EMIT; a start
// clears one row per cycle in CLEAR before EMIT. No new item is taken until the last one is
// emitted. Synchronous reset clears the control state and the walker; the lattice is not
// cleared by reset, as no step is counted before a start clears it.
`include "assert_macros.svh"

module growing_self_avoiding_walk_top #(
   parameter int unsigned DIM = gsaw_pkg::DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [gsaw_pkg::RND_W-1:0]    req_random_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gsaw_pkg::POS_W-1:0]    rsp_pos_x,
   output logic [gsaw_pkg::POS_W-1:0]    rsp_pos_y,
   output logic                          rsp_alive,
   output logic                          rsp_done_res,
   output logic [gsaw_pkg::STEP_W-1:0]   rsp_step_total,
   output logic [gsaw_pkg::SUM_W-1:0]    rsp_sum_sq_dist,
   input  logic                          csr_wr_en,
   input  logic [gsaw_pkg::STEP_W-1:0]   csr_wr_data
);
   import gsaw_pkg::*;

   cmd_type    cmd;
   status_type status;

   gsaw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   gsaw_dp #(
      .DIM (DIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_random_word (req_random_word),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_alive       (rsp_alive),
      .rsp_done_res    (rsp_done_res),
      .rsp_step_total  (rsp_step_total),
      .rsp_sum_sq_dist (rsp_sum_sq_dist)
   );

   // An accepted beat keeps the input side stalled while the item is worked on.
   `GSAW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // A result is only loaded when the output register is free.
   `GSAW_ASSERT_IMPL(a_emit_when_free, cmd.emit, !rsp_valid || !rsp_stall)
   // Loading a result always presents a beat on the next cycle.
   `GSAW_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid)
   // At most one sequencing command is active in any cycle.
   `GSAW_ASSERT_IMPL(a_cmd_onehot, 1'b1,
      $onehot0({cmd.start, cmd.step, cmd.ignore, cmd.clear, cmd.rd_r, cmd.rd_l,
                cmd.rd_c, cmd.pick, cmd.write, cmd.emit}))

endmodule

@@ test/growing_self_avoiding_walk_top_tb.sv @@
// Self-checking testbench for the growing self-avoiding walk block.
`timescale 1ns / 1ps

module growing_self_avoiding_walk_top_tb;
   import gsaw_pkg::*;

   localparam int unsigned LATTICE      = DIM_DEFAULT;
   localparam int unsigned CENTRE       = LATTICE / 2;
   localparam int          TARGET_BEATS = 1850;
   localparam int          MAX_PHASES   = 80;
   localparam int          SETTLE       = 8;

   typedef struct packed {
      logic             action;
      logic [RND_W-1:0] rnd;
   } walk_beat_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic              alive;
      logic              done_res;
      logic [STEP_W-1:0] step_total;
      logic [SUM_W-1:0]  sum_sq_dist;
   } walk_result_type;

   logic              clock;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic              req_action      = ACT_STEP;
   logic [RND_W-1:0]  req_random_word = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [POS_W-1:0]  rsp_pos_x;
   logic [POS_W-1:0]  rsp_pos_y;
   logic              rsp_alive;
   logic              rsp_done_res;
   logic [STEP_W-1:0] rsp_step_total;
   logic [SUM_W-1:0]  rsp_sum_sq_dist;
   logic              csr_wr_en       = 1'b0;
   logic [STEP_W-1:0] csr_wr_data     = '0;

   walk_beat_type   pending_beats[$];
   walk_result_type walk_results_due[$];
   int              send_idle_pct  = 0;
   int              stall_pct      = 0;
   int              error_count    = 0;
   int              accepted_beats = 0;

   // Shadow of the walker. Visited sites are also listed so that a start only
   // clears what the previous walk marked.
   bit                visit_map [LATTICE*LATTICE];
   int unsigned       marked_sites[$];
   int                walk_x = CENTRE;
   int                walk_y = CENTRE;
   bit                walk_live = 1'b0;
   logic [STEP_W-1:0] walk_steps = '0;
   logic [SUM_W-1:0]  walk_sum = '0;
   logic [STEP_W-1:0] step_cap = MAX_STEPS_RESET;

   growing_self_avoiding_walk_top #(.DIM(LATTICE)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_alive       (rsp_alive),
      .rsp_done_res    (rsp_done_res),
      .rsp_step_total  (rsp_step_total),
      .rsp_sum_sq_dist (rsp_sum_sq_dist),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void mark_site(int x, int y);
      visit_map[x*LATTICE + y] = 1'b1;
      marked_sites.push_back(x*LATTICE + y);
   endfunction

   function automatic bit site_open(int x, int y);
      if (x < 0 || x >= int'(LATTICE) || y < 0 || y >= int'(LATTICE))
         return 1'b0;
      return !visit_map[x*LATTICE + y];
   endfunction

   function automatic void neighbour(dir_type d, int x, int y, output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
         DIR_UP:    ny = y + 1;
         DIR_DOWN:  ny = y - 1;
         DIR_RIGHT: nx = x + 1;
         DIR_LEFT:  nx = x - 1;
         default:   nx = x;
      endcase
   endfunction

   // Applies one beat to the shadow walker and returns the result it should give.
   function automatic walk_result_type advance_walk(logic act, logic [RND_W-1:0] rnd);
      walk_result_type res;
      bit              open_dir[4];
      int              nfree;
      int              pick;
      int              dx;
      int              dy;
      int              nx;
      int              ny;
      if (act == ACT_START) begin
         foreach (marked_sites[i])
            visit_map[marked_sites[i]] = 1'b0;
         marked_sites.delete();
         walk_x = CENTRE;
         walk_y = CENTRE;
         mark_site(walk_x, walk_y);
         walk_live  = 1'b1;
         walk_steps = '0;
         walk_sum   = '0;
      end else if (walk_live && walk_steps < step_cap) begin
         dx = walk_x - int'(CENTRE);
         dy = walk_y - int'(CENTRE);
         walk_sum   = walk_sum + SUM_W'(dx*dx) + SUM_W'(dy*dy);
         walk_steps = walk_steps + 1'b1;
      end else begin
         return '{POS_W'(walk_x), POS_W'(walk_y), walk_live, 1'b1, walk_steps, walk_sum};
      end
      res = '{POS_W'(walk_x), POS_W'(walk_y), walk_live, 1'b0, walk_steps, walk_sum};
      if (act == ACT_STEP) begin
         nfree = 0;
         for (int i = 0; i < 4; i++) begin
            neighbour(dir_type'(i), walk_x, walk_y, nx, ny);
            open_dir[i] = site_open(nx, ny);
            if (open_dir[i])
               nfree++;
         end
         if (nfree == 0) begin
            walk_live = 1'b0;
         end else begin
            pick = (int'(rnd) * nfree) >> 16;
            for (int i = 0; i < 4; i++) begin
               if (open_dir[i]) begin
                  if (pick == 0) begin
                     neighbour(dir_type'(i), walk_x, walk_y, nx, ny);
                     walk_x = nx;
                     walk_y = ny;
                     mark_site(nx, ny);
                     break;
                  end
                  pick--;
               end
            end
         end
         res.alive = walk_live;
      end
      return res;
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= 10)
         $display("%s", msg);
   endfunction

   always @(posedge clock) begin : beat_driver
      walk_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_beats++;
            walk_results_due.push_back(advance_walk(req_action, req_random_word));
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_beats.pop_front();
               req_valid       <= 1'b1;
               req_action      <= nxt.action;
               req_random_word <= nxt.rnd;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      walk_result_type got;
      walk_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_alive, rsp_done_res, rsp_step_total,
                    rsp_sum_sq_dist};
            if (walk_results_due.size() == 0) begin
               note_failure($sformatf("unexpected result beat: x=%0d y=%0d steps=%0d",
                                      got.pos_x, got.pos_y, got.step_total));
            end else begin
               want = walk_results_due.pop_front();
               if (got !== want)
                  note_failure($sformatf({"walk mismatch: expected x=%0d y=%0d alive=%0b ",
                     "done=%0b steps=%0d sum=%0d, got x=%0d y=%0d alive=%0b done=%0b ",
                     "steps=%0d sum=%0d"},
                     want.pos_x, want.pos_y, want.alive, want.done_res, want.step_total,
                     want.sum_sq_dist, got.pos_x, got.pos_y, got.alive, got.done_res,
                     got.step_total, got.sum_sq_dist));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Sampled on the falling edge so that the driver's updates have settled.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || walk_results_due.size() != 0);
   endtask

   task automatic write_step_cap(logic [STEP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      step_cap = value;
   endtask

   task automatic push_beat(logic act, logic [RND_W-1:0] rnd);
      walk_beat_type b;
      b.action = act;
      b.rnd    = rnd;
      pending_beats.push_back(b);
   endtask

   // Straight runs with all-zero or all-ones words head up or left to the
   // lattice edge and then follow it.
   task automatic fill_phase(int n_items);
      int added;
      int roll;
      int span;
      int n;
      logic [RND_W-1:0] fixed_word;
      added = 0;
      while (added < n_items) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            push_beat(($urandom_range(9) == 0) ? ACT_START : ACT_STEP,
                      RND_W'($urandom_range(65535)));
            added++;
         end else if (roll < 12 && step_cap >= 300) begin
            fixed_word = $urandom_range(1) ? '1 : '0;
            push_beat(ACT_START, RND_W'($urandom_range(65535)));
            for (int i = 0; i < 300; i++)
               push_beat(ACT_STEP, fixed_word);
            added += 301;
         end else begin
            span = int'(step_cap) + 4;
            if (span > 200)
               span = 200;
            n = $urandom_range(span, 1);
            push_beat(ACT_START, RND_W'($urandom_range(65535)));
            for (int i = 0; i < n; i++)
               push_beat(ACT_STEP, RND_W'($urandom_range(65535)));
            added += n + 1;
         end
      end
   endtask

   initial begin : stimulus
      logic [RND_W-1:0] early_words[10];
      logic [STEP_W-1:0] cap_value;
      int phase;
      int n_items;
      early_words = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555,
                      16'hAAAA, 16'h4000, 16'hBFFF, 16'h0001, 16'hFFFE};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A step before any walk exists is ignored; then extreme words, a restart
      // in mid-walk and two starts back to back.
      push_beat(ACT_STEP, 16'hFFFF);
      push_beat(ACT_START, 16'h0000);
      foreach (early_words[i])
         push_beat(ACT_STEP, early_words[i]);
      push_beat(ACT_START, 16'h1234);
      push_beat(ACT_START, 16'hFFFF);
      push_beat(ACT_STEP, 16'h0000);
      push_beat(ACT_STEP, 16'h0000);
      push_beat(ACT_STEP, 16'h0000);
      push_beat(ACT_STEP, 16'hFFFF);
      push_beat(ACT_STEP, 16'hFFFF);
      push_beat(ACT_STEP, 16'hC000);

      phase = 0;
      wait_drained();
      while (accepted_beats < TARGET_BEATS && phase < MAX_PHASES) begin
         repeat (SETTLE) @(posedge clock);
         n_items = 220;
         case (phase % 6)
            0: cap_value = '1;
            1: begin
               cap_value = 16'd1;
               n_items = 60;
            end
            2: begin
               cap_value = '0;
               n_items = 25;
            end
            3: cap_value = MAX_STEPS_RESET;
            4: cap_value = STEP_W'($urandom_range(60, 2));
            default: cap_value = STEP_W'($urandom_range(400, 61));
         endcase
         write_step_cap(cap_value);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               send_idle_pct = 27;
               stall_pct = 27;
            end
         endcase
         @(negedge clock);
         fill_phase(n_items);
         phase++;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && walk_results_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ growing_self_avoiding_walk_top.f @@
+incdir+rtl/core
rtl/core/gsaw_pkg.sv
rtl/core/gsaw_ram.sv
rtl/core/gsaw_ctrl.sv
rtl/core/gsaw_dp.sv
rtl/core/growing_self_avoiding_walk_top.sv
test/growing_self_avoiding_walk_top_tb.sv
